// File: hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit
// Fixed-point formats, operation codes, CORDIC arctangent table and the
// saturation helpers used by the front end, the CORDIC cells and the back end.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Data format: signed Q3.12
  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;

  // Operation codes
  localparam int OP_W = 3;
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_CONJ  = 3'd3,
    OP_SCALE = 3'd4,
    OP_EQUAL = 3'd5,
    OP_POLAR = 3'd6
  } op_e;

  // Widths of internal datapaths
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = 2 * DATA_WIDTH + 2;
  localparam int XW         = DATA_WIDTH + GUARD_BITS + 3;
  localparam int Z_FRAC     = 30;
  localparam int ZW         = Z_FRAC + 4;
  localparam int STEP_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ATAN_IDX_W = 5;

  // Phase constants in Q30
  localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);

  // CORDIC gain correction 1/K in Q30, applied as two partial products
  localparam int KINV_W                = 30;
  localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;
  localparam int KSPLIT    = 16;
  localparam int MAG_HI_W  = XW - KSPLIT + KINV_W;
  localparam int MAG_LO_W  = KSPLIT + KINV_W;
  localparam int MAG_SUM_W = MAG_HI_W + 1;
  localparam int MAG_SHIFT = Z_FRAC + GUARD_BITS - KSPLIT;
  localparam int PH_SHIFT  = Z_FRAC - FRAC_BITS;

  // Rounding offsets (half of the dropped LSB)
  localparam logic signed [ACC_W-1:0]   HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ZW-1:0]      PH_HALF  = ZW'(1) << (PH_SHIFT - 1);
  localparam logic [MAG_SUM_W-1:0]      MAG_HALF = MAG_SUM_W'(1) << (MAG_SHIFT - 1);

  // Saturation limits
  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // CORDIC vector travelling down the cell chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // Side results that ride along with the vector
  typedef struct packed {
    logic                         is_polar;
    logic                         is_zero;
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         eq;
    logic                         sat;
  } side_t;

  // Arctangent of 2^-i in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = ZW'(843314857);
      5'd1:    r = ZW'(497837829);
      5'd2:    r = ZW'(263043837);
      5'd3:    r = ZW'(133525159);
      5'd4:    r = ZW'(67021687);
      5'd5:    r = ZW'(33543516);
      5'd6:    r = ZW'(16775851);
      5'd7:    r = ZW'(8388437);
      5'd8:    r = ZW'(4194283);
      5'd9:    r = ZW'(2097149);
      5'd10:   r = ZW'(1048576);
      5'd11:   r = ZW'(524288);
      5'd12:   r = ZW'(262144);
      5'd13:   r = ZW'(131072);
      5'd14:   r = ZW'(65536);
      5'd15:   r = ZW'(32768);
      5'd16:   r = ZW'(16384);
      5'd17:   r = ZW'(8192);
      5'd18:   r = ZW'(4096);
      5'd19:   r = ZW'(2048);
      5'd20:   r = ZW'(1024);
      5'd21:   r = ZW'(512);
      5'd22:   r = ZW'(256);
      5'd23:   r = ZW'(128);
      5'd24:   r = ZW'(64);
      5'd25:   r = ZW'(32);
      5'd26:   r = ZW'(16);
      5'd27:   r = ZW'(8);
      5'd28:   r = ZW'(4);
      5'd29:   r = ZW'(2);
      5'd30:   r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // True when a wide value lies outside the data range
  function automatic logic ovf(input logic signed [ACC_W-1:0] v);
    return (v > ACC_W'(DATA_MAX)) || (v < ACC_W'(DATA_MIN));
  endfunction

  // Clip a wide value to the data range
  function automatic logic signed [DATA_WIDTH-1:0] clip(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if (v > ACC_W'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < ACC_W'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: operand capture, products and rectangular results
// Stage one registers the operands and the four cross products. Stage two
// rounds and saturates the rectangular results and sets up the CORDIC vector
// (pre-rotated by pi into the right half plane).
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [cau_pkg::OP_W-1:0]               req_type_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output cau_pkg::vec_t                          vec_o,
  output cau_pkg::side_t                         side_o
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int AW = cau_pkg::ACC_W;
  localparam int XW = cau_pkg::XW;

  logic                            s1_valid_q;
  logic                            s1_ready;
  logic [cau_pkg::OP_W-1:0]        op_q;
  logic signed [DW-1:0]            ar_q, ai_q, br_q, bi_q;
  logic signed [cau_pkg::PROD_W-1:0] pp_rr_q, pp_ii_q, pp_ri_q, pp_ir_q;

  logic                            s2_valid_q;
  logic                            s2_ready;
  cau_pkg::vec_t                   vec_d, vec_q;
  cau_pkg::side_t                  side_d, side_q;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // Stage one: capture operands and form products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      op_q    <= req_type_i;
      ar_q    <= a_re_i;
      ai_q    <= a_im_i;
      br_q    <= b_re_i;
      bi_q    <= b_im_i;
      pp_rr_q <= a_re_i * b_re_i;
      pp_ii_q <= a_im_i * b_im_i;
      pp_ri_q <= a_re_i * b_im_i;
      pp_ir_q <= a_im_i * b_re_i;
    end
  end

  // Stage two: combine, round and saturate; set up the polar vector
  always_comb begin
    logic signed [AW-1:0] re_w;
    logic signed [AW-1:0] im_w;
    logic signed [XW-1:0] ar_x;
    logic signed [XW-1:0] ai_x;
    re_w   = '0;
    im_w   = '0;
    side_d = '0;
    case (cau_pkg::op_e'(op_q))
      cau_pkg::OP_ADD: begin
        re_w = AW'(ar_q) + AW'(br_q);
        im_w = AW'(ai_q) + AW'(bi_q);
      end
      cau_pkg::OP_SUB: begin
        re_w = AW'(ar_q) - AW'(br_q);
        im_w = AW'(ai_q) - AW'(bi_q);
      end
      cau_pkg::OP_MUL: begin
        re_w = (AW'(pp_rr_q) - AW'(pp_ii_q) + cau_pkg::HALF_LSB) >>> cau_pkg::FRAC_BITS;
        im_w = (AW'(pp_ri_q) + AW'(pp_ir_q) + cau_pkg::HALF_LSB) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::OP_CONJ: begin
        re_w = AW'(ar_q);
        im_w = -AW'(ai_q);
      end
      cau_pkg::OP_SCALE: begin
        re_w = (AW'(pp_rr_q) + cau_pkg::HALF_LSB) >>> cau_pkg::FRAC_BITS;
        im_w = (AW'(pp_ir_q) + cau_pkg::HALF_LSB) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::OP_EQUAL: begin
        side_d.eq = (ar_q == br_q) && (ai_q == bi_q);
      end
      cau_pkg::OP_POLAR: begin
        side_d.is_polar = 1'b1;
      end
      default: begin
        re_w = '0;
        im_w = '0;
      end
    endcase
    side_d.re      = cau_pkg::clip(re_w);
    side_d.im      = cau_pkg::clip(im_w);
    side_d.sat     = cau_pkg::ovf(re_w) || cau_pkg::ovf(im_w);
    side_d.is_zero = (ar_q == '0) && (ai_q == '0);

    // Rotate by pi into the right half plane when the real part is negative
    ar_x = XW'(ar_q);
    ai_x = XW'(ai_q);
    if (ar_q < 0) begin
      vec_d.x = (-ar_x) <<< cau_pkg::GUARD_BITS;
      vec_d.y = (-ai_x) <<< cau_pkg::GUARD_BITS;
      vec_d.z = (ai_q >= 0) ? cau_pkg::PI_Q30 : -cau_pkg::PI_Q30;
    end else begin
      vec_d.x = ar_x <<< cau_pkg::GUARD_BITS;
      vec_d.y = ai_x <<< cau_pkg::GUARD_BITS;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      vec_q  <= vec_d;
      side_q <= side_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

// File: hw/rtl/cau_cell.sv
// ----------------------------------------------------------------------------
// cau_cell: one CORDIC vectoring iteration
// Rotates the vector toward the positive x axis by atan(2^-step), accumulates
// the angle and hands vector and side results on to the next cell.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cau_pkg::STEP_W-1:0]    step_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  cau_pkg::vec_t                 vec_i,
  input  cau_pkg::side_t                side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output cau_pkg::vec_t                 vec_o,
  output cau_pkg::side_t                side_o
);

  logic                            valid_q;
  cau_pkg::vec_t                   vec_d, vec_q;
  cau_pkg::side_t                  side_q;
  logic signed [cau_pkg::XW-1:0]   dx, dy;
  logic signed [cau_pkg::ZW-1:0]   angle;

  assign ready_o = !valid_q || ready_i;

  // Rotate clockwise while y is non-negative, else counter-clockwise
  assign dx    = vec_i.y >>> step_i;
  assign dy    = vec_i.x >>> step_i;
  assign angle = cau_pkg::atan_q30(cau_pkg::ATAN_IDX_W'(step_i));

  always_comb begin
    if (!vec_i.y[cau_pkg::XW-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + angle;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

// File: hw/rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back: gain correction, result select and output register
// Stage one multiplies the CORDIC magnitude by 1/K in two partial products
// and rounds the phase. The output stage sums, rounds and saturates, picks
// the polar or rectangular result and holds it until the transfer.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  cau_pkg::vec_t                          vec_i,
  input  cau_pkg::side_t                         side_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]  res_re_o,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]  res_im_o,
  output logic                                   is_equal_o,
  output logic                                   saturated_o
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int AW = cau_pkg::ACC_W;
  localparam int ZW = cau_pkg::ZW;

  logic                              m_valid_q;
  logic                              m_ready;
  logic [cau_pkg::XW-1:0]            ux;
  logic [cau_pkg::MAG_LO_W-1:0]      lo_full;
  logic [cau_pkg::MAG_HI_W-1:0]      prod_hi_q;
  logic [cau_pkg::KINV_W-1:0]        prod_lo_q;
  logic signed [ZW-1:0]              ph_q;
  cau_pkg::side_t                    side_q;

  logic                              o_valid_q;
  logic                              o_ready;
  logic [cau_pkg::MAG_SUM_W-1:0]     mag_sum;
  logic signed [AW-1:0]              mag_w;
  logic signed [AW-1:0]              ph_w;
  logic signed [DW-1:0]              re_d, im_d, re_q, im_q;
  logic                              eq_d, sat_d, eq_q, sat_q;

  assign o_ready = !o_valid_q || !out_stall_i;
  assign m_ready = !m_valid_q || o_ready;
  assign ready_o = m_ready;

  // Gain correction partial products; x is never negative here
  assign ux      = unsigned'(vec_i.x);
  assign lo_full = ux[cau_pkg::KSPLIT-1:0] * cau_pkg::KINV_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_ready) begin
      m_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready) begin
      prod_hi_q <= ux[cau_pkg::XW-1:cau_pkg::KSPLIT] * cau_pkg::KINV_Q30;
      prod_lo_q <= lo_full[cau_pkg::MAG_LO_W-1:cau_pkg::KSPLIT];
      ph_q      <= (vec_i.z + cau_pkg::PH_HALF) >>> cau_pkg::PH_SHIFT;
      side_q    <= side_i;
    end
  end

  // Sum, round and saturate; select the result
  always_comb begin
    mag_sum = cau_pkg::MAG_SUM_W'(prod_hi_q) + cau_pkg::MAG_SUM_W'(prod_lo_q)
              + cau_pkg::MAG_HALF;
    mag_w   = AW'(mag_sum >> cau_pkg::MAG_SHIFT);
    ph_w    = AW'(ph_q);
    if (side_q.is_polar) begin
      if (side_q.is_zero) begin
        re_d  = '0;
        im_d  = '0;
        sat_d = 1'b0;
      end else begin
        re_d  = cau_pkg::clip(mag_w);
        im_d  = cau_pkg::clip(ph_w);
        sat_d = cau_pkg::ovf(mag_w) || cau_pkg::ovf(ph_w);
      end
      eq_d = 1'b0;
    end else begin
      re_d  = side_q.re;
      im_d  = side_q.im;
      sat_d = side_q.sat;
      eq_d  = side_q.eq;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready) begin
      re_q  <= re_d;
      im_q  <= im_d;
      eq_q  <= eq_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign res_re_o    = re_q;
  assign res_im_o    = im_q;
  assign is_equal_o  = eq_q;
  assign saturated_o = sat_q;

endmodule

// File: hw/rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex ALU with CORDIC polar conversion
// Add, subtract, multiply, conjugate, scale, equality and polar form on
// signed Q3.12 operands, with saturation and a saturated flag.
// ----------------------------------------------------------------------------
// The unit takes one operation per clock while the input is not stalled;
// each result passes two front stages (operand capture with the four
// products, then rounding and CORDIC setup), a chain of 16 CORDIC cells at
// one iteration per cell, a gain correction stage and the output register.
// Every operation travels the full chain, so results leave in input order.
// A stall on the output holds the output register only; empty stages further
// up keep filling, and the input stalls once the whole chain is occupied.
// The unit holds no state between items.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [cau_pkg::OP_W-1:0]               req_type_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]  res_re_o,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]  res_im_o,
  output logic                                   is_equal_o,
  output logic                                   saturated_o
);

  localparam int N = cau_pkg::CORDIC_STEPS;

  logic            front_ready;
  logic            valid_c [N+1];
  logic            ready_c [N+1];
  cau_pkg::vec_t   vec_c   [N+1];
  cau_pkg::side_t  side_c  [N+1];

  assign in_stall_o = !front_ready;

  // Operand capture and rectangular results
  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (front_ready),
    .req_type_i (req_type_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .valid_o    (valid_c[0]),
    .ready_i    (ready_c[0]),
    .vec_o      (vec_c[0]),
    .side_o     (side_c[0])
  );

  // CORDIC cell chain, one iteration per cell
  for (genvar k = 0; k < N; k++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (cau_pkg::STEP_W'(k)),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .vec_i   (vec_c[k]),
      .side_i  (side_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .vec_o   (vec_c[k+1]),
      .side_o  (side_c[k+1])
    );
  end

  // Gain correction and output register
  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_c[N]),
    .ready_o     (ready_c[N]),
    .vec_i       (vec_c[N]),
    .side_i      (side_c[N]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_re_o    (res_re_o),
    .res_im_o    (res_im_o),
    .is_equal_o  (is_equal_o),
    .saturated_o (saturated_o)
  );

endmodule

// File: hw/rtl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex arithmetic unit
// Watches the top-level ports and flags result patterns that cannot occur.
// ----------------------------------------------------------------------------
module cau_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  res_re_o,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  res_im_o,
  input  logic                                   is_equal_o,
  input  logic                                   saturated_o
);

  // Stalled result holds until the transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_re_o)
      && $stable(res_im_o) && $stable(is_equal_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // An equality hit carries no numeric result
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> res_re_o == '0 && res_im_o == '0 && !saturated_o)
    else $error("equality result with numeric payload");

  // A clipped result sits at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      res_re_o == cau_pkg::DATA_MAX || res_re_o == cau_pkg::DATA_MIN
      || res_im_o == cau_pkg::DATA_MAX || res_im_o == cau_pkg::DATA_MIN)
    else $error("saturated flag without a clipped part");

  // No result leaves right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
